[rtl/assert_macros.svh]
// Assertion macros for the RTL files, included by lserk_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/lserk_pkg.sv]
// ---------------------------------------------------------------------------
// lserk_pkg: shared types and constants
// Function codes, controller states, command/status structs, LSERK4 tables.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lserk_pkg;
  localparam int DataW = 32;
  localparam int IdxW  = 4;

  typedef enum logic [2:0] {
    FUNC_LOAD_OP    = 3'd0,
    FUNC_LOAD_CPL   = 3'd1,
    FUNC_LOAD_STATE = 3'd2,
    FUNC_LOAD_FORCE = 3'd3,
    FUNC_STEP       = 3'd4
  } func_t;

  localparam logic [7:0] REG_STEP_SIZE = 8'd0;
  localparam logic [7:0] REG_FORCING   = 8'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RHS,
    ST_UPD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    MAC_NONE,
    MAC_OP,
    MAC_CPL
  } mac_sel_t;

  typedef struct packed {
    logic        clear_res;
    logic        acc_clear;
    mac_sel_t    mac_sel;
    logic        rhs_write;
    logic        upd_ph;
    logic        upd_write;
    logic [2:0]  stage;
  } dp_cmd_t;

  typedef struct packed {
    logic unused;
  } dp_stat_t;

  function automatic logic signed [31:0] coef_a(input logic [2:0] s);
    case (s)
      3'd1:    return -32'sd448706480;
      3'd2:    return -32'sd1280063135;
      3'd3:    return -32'sd1822982432;
      3'd4:    return -32'sd1625842093;
      default: return 32'sd0;
    endcase
  endfunction

  function automatic logic signed [31:0] coef_b(input logic [2:0] s);
    case (s)
      3'd0:    return 32'sd160695151;
      3'd1:    return 32'sd407173973;
      3'd2:    return 32'sd883641234;
      3'd3:    return 32'sd751029208;
      default: return 32'sd164343969;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) return 32'sh7fffffff;
    if (v < -72'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // floor((p + 2^(sh-1)) >> sh), arithmetic
  function automatic logic signed [63:0] rnd24(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd8388608;
    return t >>> 24;
  endfunction

  function automatic logic signed [63:0] rnd30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd536870912;
    return t >>> 30;
  endfunction
endpackage
`default_nettype wire

[rtl/lserk_if.sv]
// ---------------------------------------------------------------------------
// lserk_if: channel interfaces
// Input, result and configuration valid/ready channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface lserk_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [3:0]  row;
  logic [3:0]  col;
  logic signed [31:0] value;
  modport source (output valid, func, row, col, value, input ready);
  modport sink (input valid, func, row, col, value, output ready);
endinterface

interface lserk_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic signed [31:0] state_value;
  logic        last;
  modport source (output valid, index, state_value, last, input ready);
  modport sink (input valid, index, state_value, last, output ready);
endinterface

interface lserk_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/reduced_lserk4_stepper.sv]
// ---------------------------------------------------------------------------
// reduced_lserk4_stepper: reduced-order LSERK4 time stepper
// Load items fill matrices and vectors; a step item emits the new state.
// ---------------------------------------------------------------------------
// A step clears the residuals, then runs the one MAC walking the operators
// row by row (the coupling matrix too, with forcing) and the stage updates;
// then STATE_DIM results, one per accepted output transaction.
`timescale 1ns / 1ps
`default_nettype none
module reduced_lserk4_stepper #(
  parameter int STATE_DIM = 16,
  parameter int INPUT_DIM = 16
) (
  input wire logic     clk,
  input wire logic     rst,
  lserk_in_if.sink     in_ch,
  lserk_out_if.source  out_ch,
  lserk_cfg_if.sink    cfg
);
  import lserk_pkg::*;

  logic [30:0] step_size;
  logic        forcing_enable;
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic        busy, out_valid;
  logic [3:0]  row_i, col_j;
  logic signed [31:0] y_out;
  logic        acc_in, start;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= '0; forcing_enable <= 1'b0;
    end else if (cfg.valid) begin
      if (cfg.index == REG_STEP_SIZE) step_size <= cfg.data[30:0];
      else if (cfg.index == REG_FORCING) forcing_enable <= cfg.data[0];
    end
  end

  assign in_ch.ready = !busy;
  assign acc_in = in_ch.valid && in_ch.ready;
  assign start  = acc_in && in_ch.func == FUNC_STEP;

  lserk_datapath #(.StateDim(STATE_DIM), .InputDim(INPUT_DIM)) u_dp (
    .clk(clk), .rst(rst), .load_en(acc_in), .load_func(in_ch.func),
    .load_row(in_ch.row), .load_col(in_ch.col), .load_value(in_ch.value),
    .step_size(step_size), .cmd(cmd), .row_i(row_i), .col_j(col_j),
    .stat(stat), .y_out(y_out));

  lserk_ctrl #(.StateDim(STATE_DIM), .InputDim(INPUT_DIM)) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .forcing(forcing_enable),
    .out_ready(out_ch.ready), .stat(stat), .cmd(cmd), .busy(busy),
    .out_valid(out_valid), .row_i(row_i), .col_j(col_j));

  assign out_ch.valid       = out_valid;
  assign out_ch.index       = row_i;
  assign out_ch.state_value = y_out;
  assign out_ch.last        = 32'(row_i) == STATE_DIM - 1;
endmodule
`default_nettype wire

[rtl/lserk_ram.sv]
// ---------------------------------------------------------------------------
// lserk_ram: generic single-port-write RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lserk_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/lserk_datapath.sv]
// ---------------------------------------------------------------------------
// lserk_datapath: matrices, vectors, MAC and stage update
// One MAC over RAM-held operators, serial per-element stage update.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lserk_datapath #(
  parameter int StateDim = 16,
  parameter int InputDim = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    load_en,
  input  wire logic [2:0]              load_func,
  input  wire logic [3:0]              load_row,
  input  wire logic [3:0]              load_col,
  input  wire logic signed [31:0]      load_value,
  input  wire logic [30:0]             step_size,
  input  wire lserk_pkg::dp_cmd_t      cmd,
  input  wire logic [3:0]              row_i,
  input  wire logic [3:0]              col_j,
  output lserk_pkg::dp_stat_t          stat,
  output logic signed [31:0]           y_out
);
  import lserk_pkg::*;

  localparam int OpAw = 8;
  logic signed [31:0] y   [16];
  logic signed [31:0] u   [16];
  logic signed [31:0] res [16];
  logic signed [31:0] rhs [16];

  logic [OpAw-1:0] op_waddr, op_raddr;
  logic signed [31:0] op_rd, cpl_rd;
  logic op_we, cpl_we;

  assign op_waddr = {load_row, load_col};
  assign op_raddr = {row_i, col_j};
  assign op_we  = load_en && load_func == FUNC_LOAD_OP &&
                  32'(load_row) < StateDim && 32'(load_col) < StateDim;
  assign cpl_we = load_en && load_func == FUNC_LOAD_CPL &&
                  32'(load_row) < StateDim && 32'(load_col) < InputDim;

  lserk_ram #(.Width(32), .Depth(256)) u_op (
    .clk(clk), .we(op_we), .waddr(op_waddr), .wdata(load_value),
    .raddr(op_raddr), .rdata(op_rd));
  lserk_ram #(.Width(32), .Depth(256)) u_cpl (
    .clk(clk), .we(cpl_we), .waddr(op_waddr), .wdata(load_value),
    .raddr(op_raddr), .rdata(cpl_rd));

  // MAC pipeline stages, in order: address, RAM data + vector operand,
  // product register, accumulate
  mac_sel_t sel1, sel2;
  logic signed [31:0] vec1;
  logic signed [63:0] prod;
  logic signed [47:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel1 <= MAC_NONE;
      sel2 <= MAC_NONE;
    end else begin
      sel1 <= cmd.mac_sel;
      sel2 <= sel1;
    end
    vec1 <= (cmd.mac_sel == MAC_CPL) ? u[col_j] : y[col_j];
    prod <= ((sel1 == MAC_CPL) ? cpl_rd : op_rd) * vec1;
    if (cmd.acc_clear) acc <= '0;
    else if (sel2 != MAC_NONE) acc <= acc + 48'(rnd24(prod));
  end

  // stage update, two phases: residual then state
  logic signed [63:0] pa, pd, pb;
  logic signed [31:0] res_new;
  assign res_new = sat32(72'(rnd30(pa)) + 72'(rnd24(pd)));

  always_ff @(posedge clk) begin
    pa <= 64'(coef_a(cmd.stage)) * 64'(res[row_i]);
    pd <= $signed({33'd0, step_size}) * 64'(rhs[row_i]);
    pb <= 64'(coef_b(cmd.stage)) * 64'(res[row_i]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 16; k++) begin
        y[k] <= '0; u[k] <= '0; res[k] <= '0; rhs[k] <= '0;
      end
    end else begin
      if (load_en && load_func == FUNC_LOAD_STATE && 32'(load_row) < StateDim)
        y[load_row] <= load_value;
      if (load_en && load_func == FUNC_LOAD_FORCE && 32'(load_row) < InputDim)
        u[load_row] <= load_value;
      if (cmd.clear_res) res[row_i] <= '0;
      if (cmd.rhs_write) rhs[row_i] <= sat32(72'(acc));
      if (cmd.upd_write && !cmd.upd_ph) res[row_i] <= res_new;
      if (cmd.upd_write && cmd.upd_ph)
        y[row_i] <= sat32(72'(y[row_i]) + 72'(rnd30(pb)));
    end
  end

  assign y_out = y[row_i];
  assign stat.unused = 1'b0;
endmodule
`default_nettype wire

[rtl/lserk_ctrl.sv]
// ---------------------------------------------------------------------------
// lserk_ctrl: step sequencer
// Walks stages, rows and columns and drives the datapath commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lserk_ctrl #(
  parameter int StateDim = 16,
  parameter int InputDim = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               forcing,
  input  wire logic               out_ready,
  input  wire lserk_pkg::dp_stat_t stat,
  output lserk_pkg::dp_cmd_t      cmd,
  output logic                    busy,
  output logic                    out_valid,
  output logic [3:0]              row_i,
  output logic [3:0]              col_j
);
  import lserk_pkg::*;

  localparam int Lat = 3;
  state_t state, state_next;
  logic [2:0] stage;
  logic [4:0] cnt;     // column/phase counter incl. drain cycles
  logic       ph;      // 0 operator pass, 1 coupling pass
  logic [3:0] row;
  logic [4:0] cnt_last;

  assign cnt_last = ph ? 5'(InputDim + Lat) : 5'(StateDim + Lat);
  logic [4:0] colw;
  assign colw = ph ? 5'(InputDim) : 5'(StateDim);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) state_next = ST_CLEAR;
      ST_CLEAR: if (32'(row) == StateDim - 1) state_next = ST_RHS;
      ST_RHS:   if (cnt == cnt_last && (ph || !forcing) && 32'(row) == StateDim - 1)
                  state_next = ST_UPD;
      ST_UPD:   if (cnt == 5'd3 && 32'(row) == StateDim - 1)
                  state_next = (stage == 3'd4) ? ST_OUT : ST_RHS;
      ST_OUT:   if (out_ready && 32'(row) == StateDim - 1) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; stage <= '0; cnt <= '0; ph <= 1'b0; row <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          stage <= '0; cnt <= '0; ph <= 1'b0; row <= '0;
        end
        ST_CLEAR: row <= (32'(row) == StateDim - 1) ? '0 : row + 4'd1;
        ST_RHS: begin
          if (cnt == cnt_last) begin
            cnt <= '0;
            if (!ph && forcing) ph <= 1'b1;
            else begin
              ph <= 1'b0;
              row <= (32'(row) == StateDim - 1) ? '0 : row + 4'd1;
            end
          end else cnt <= cnt + 5'd1;
        end
        ST_UPD: begin
          if (cnt == 5'd3) begin
            cnt <= '0;
            if (32'(row) == StateDim - 1) begin
              row <= '0; stage <= stage + 3'd1;
            end else row <= row + 4'd1;
          end else cnt <= cnt + 5'd1;
        end
        ST_OUT: if (out_ready) row <= row + 4'd1;
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.stage = stage;
    busy = state != ST_IDLE;
    out_valid = state == ST_OUT;
    row_i = row;
    col_j = cnt[3:0];
    case (state)
      ST_CLEAR: cmd.clear_res = 1'b1;
      ST_RHS: begin
        cmd.acc_clear = cnt == 5'd0 && !ph;
        if (cnt < colw) cmd.mac_sel = ph ? MAC_CPL : MAC_OP;
        cmd.rhs_write = cnt == cnt_last && (ph || !forcing);
      end
      ST_UPD: begin
        cmd.upd_ph    = cnt == 5'd3;
        cmd.upd_write = cnt == 5'd1 || cnt == 5'd3;
      end
      default: ;
    endcase
  end

  `ASSERT_IMPL(a_out_only_out, clk, rst, out_valid, state == ST_OUT, "out_valid outside ST_OUT")
  `ASSERT_IMPL(a_stage_range, clk, rst, busy, stage <= 3'd4 || state == ST_OUT, "stage out of range")
  `ASSERT_NEXT(a_start_leaves_idle, clk, rst, state == ST_IDLE && start, state == ST_CLEAR, "step did not start")
endmodule
`default_nettype wire
